>>> rtl/rcfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcfb_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChanWidth   = 12;
  localparam int unsigned ScaledWidth = 16;
  localparam int unsigned FrameLen    = 21;
  localparam int unsigned CrcSpan     = 19;
  localparam int unsigned IdxWidth    = $clog2(FrameLen);

  localparam logic [IdxWidth-1:0] IdxFirstData = IdxWidth'(3);
  localparam logic [IdxWidth-1:0] IdxCrcHi     = IdxWidth'(CrcSpan);
  localparam logic [IdxWidth-1:0] IdxCrcLo     = IdxWidth'(FrameLen - 1);

  // Header bytes
  localparam logic [7:0] HdrStart  = 8'hA8;
  localparam logic [7:0] HdrStatus = 8'h01;
  localparam logic [7:0] HdrCount  = 8'h08;

  localparam logic [15:0] CrcPolyReset = 16'h1021;

  // Scaling: floor((v + 375) * 32 / 5) = 6x + floor(2x / 5), x = v + 375
  localparam logic [12:0] ScaleOffset = 13'd375;
  // floor(y / 5) = (y * 52429) >> 18, exact for y well beyond 2 * 4470
  localparam logic [15:0] RecipFive   = 16'd52429;
  localparam int unsigned RecipShift  = 18;

  typedef struct packed {
    logic [ChanWidth-1:0] channel_0;
    logic [ChanWidth-1:0] channel_1;
    logic [ChanWidth-1:0] channel_2;
    logic [ChanWidth-1:0] channel_3;
    logic [ChanWidth-1:0] channel_4;
    logic [ChanWidth-1:0] channel_5;
    logic [ChanWidth-1:0] channel_6;
    logic [ChanWidth-1:0] channel_7;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  typedef logic [ChanWidth-1:0]   chan_t;
  typedef logic [ScaledWidth-1:0] scaled_t;

  // One byte of an MSB-first CRC-16, zero init, no final xor
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rc_channel_frame_builder_crc16_top.sv
`timescale 1ns / 1ps
`default_nettype none

// RC channel frame builder with CRC-16.
// Input channel (in_valid_i / in_ready_o / in_item_i): one word holds eight
// raw 12-bit channel values. Output channel (out_valid_o / out_ready_i /
// out_item_o): one word per frame byte, 21 words per input word: header
// A8 01 08, eight values offset by 375 and scaled by 6.4, high byte first,
// then the CRC-16 high byte and low byte; last_byte marks the CRC low byte.
// cfg_we_i / cfg_wdata_i write the CRC polynomial; write only while idle.
// Path: the taken word goes through the input register into the serializer,
// whose output register holds the first byte. Throughput: one byte per
// cycle while out_ready_i is high; the byte serializer sets the rate. The
// input register takes the next word while the current frame is being
// sent; the new frame follows the last byte of the previous with no gap.
// Reset: all channels empty, polynomial back to 0x1021.
// Stall: when out_ready_i is low the output word holds, the serializer
// pauses, and once the input register is full in_ready_o drops.
module rc_channel_frame_builder_crc16_top import rcfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  logic [15:0] crc_poly_q;
  logic        in_valid_q;
  in_item_t    in_q;
  logic        load_ready;
  chan_t       chans  [NumChannels];
  scaled_t     scaled [NumChannels];

  // Polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= CrcPolyReset;
    end else if (cfg_we_i) begin
      crc_poly_q <= cfg_wdata_i;
    end
  end

  // Input register
  assign in_ready_o = !in_valid_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  assign chans[0] = in_q.channel_0;
  assign chans[1] = in_q.channel_1;
  assign chans[2] = in_q.channel_2;
  assign chans[3] = in_q.channel_3;
  assign chans[4] = in_q.channel_4;
  assign chans[5] = in_q.channel_5;
  assign chans[6] = in_q.channel_6;
  assign chans[7] = in_q.channel_7;

  rcfb_scaler u_scaler (
    .chan_i   (chans),
    .scaled_o (scaled)
  );

  rcfb_frame_gen u_frame_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .crc_poly_i   (crc_poly_q),
    .load_valid_i (in_valid_q),
    .load_ready_o (load_ready),
    .scaled_i     (scaled),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/rcfb_scaler.sv
`timescale 1ns / 1ps
`default_nettype none

// Eight parallel lanes, each offsetting one raw channel by 375 and scaling it by 6.4
module rcfb_scaler import rcfb_pkg::*; (
  input  wire chan_t   chan_i   [NumChannels],
  output scaled_t      scaled_o [NumChannels]
);

  for (genvar g = 0; g < NumChannels; g++) begin : g_lane
    logic [12:0] x;
    logic [13:0] y;
    logic [29:0] prod;
    logic [15:0] six_x;
    logic [15:0] fifth;

    assign x     = {1'b0, chan_i[g]} + ScaleOffset;
    assign y     = {x, 1'b0};
    // y / 5 by reciprocal multiply
    assign prod  = 30'(y) * 30'(RecipFive);
    assign fifth = 16'(prod >> RecipShift);
    assign six_x = {1'b0, x, 2'b00} + {2'b00, x, 1'b0};
    assign scaled_o[g] = six_x + fifth;
  end

endmodule

`default_nettype wire

>>> rtl/rcfb_frame_gen.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte serializer with running CRC and an output register
module rcfb_frame_gen import rcfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] crc_poly_i,
  input  wire logic        load_valid_i,
  output logic             load_ready_o,
  input  wire scaled_t     scaled_i [NumChannels],
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  logic                busy_q, busy_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [15:0]         crc_q, crc_d;
  scaled_t             data_q [NumChannels];
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q;

  logic                advance;
  logic                at_last;
  logic                load;
  logic [7:0]          cur_byte;
  logic [IdxWidth-1:0] data_off;
  logic [2:0]          data_sel;
  scaled_t             data_word;

  // Step control
  assign advance      = busy_q && (!out_valid_q || out_ready_i);
  assign at_last      = (idx_q == IdxCrcLo);
  assign load_ready_o = !busy_q || (advance && at_last);
  assign load         = load_valid_i && load_ready_o;

  // Byte select
  assign data_off  = idx_q - IdxFirstData;
  assign data_sel  = data_off[3:1];
  assign data_word = data_q[data_sel];

  always_comb begin
    priority if (idx_q == IdxWidth'(0)) begin
      cur_byte = HdrStart;
    end else if (idx_q == IdxWidth'(1)) begin
      cur_byte = HdrStatus;
    end else if (idx_q == IdxWidth'(2)) begin
      cur_byte = HdrCount;
    end else if (idx_q == IdxCrcHi) begin
      cur_byte = crc_q[15:8];
    end else if (idx_q == IdxCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (data_off[0]) begin
      cur_byte = data_word[7:0];
    end else begin
      cur_byte = data_word[15:8];
    end
  end

  // Next state
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + IdxWidth'(1);
      if (idx_q < IdxCrcHi) begin
        crc_d = crc16_byte(crc_q, cur_byte, crc_poly_i);
      end
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
      crc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      data_q <= scaled_i;
    end
    if (advance) begin
      out_q.frame_byte <= cur_byte;
      out_q.last_byte  <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
